/* rtl/core/bb3_pkg.sv */
//----------------------------------------------------------------------------
// bb3_pkg: shared types and constants for the 3x3 RGB box blur
// Pixel and command formats, register indexes, divider constants.
//----------------------------------------------------------------------------
package bb3_pkg;

  // Field widths
  localparam int CHAN_WIDTH     = 8;
  localparam int FW_WIDTH       = 11;            // frame_width register
  localparam int FH_WIDTH       = 12;            // frame_height register
  localparam int ROW_WIDTH      = FH_WIDTH + 1;  // row counter reaches height + 1
  localparam int CFG_IDX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH = 12;

  // Register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Register reset values and geometry floor
  localparam logic [FW_WIDTH-1:0] FRAME_WIDTH_RESET  = 11'd640;
  localparam logic [FH_WIDTH-1:0] FRAME_HEIGHT_RESET = 12'd480;
  localparam int                  MIN_DIM            = 3;

  // Item opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Queue depths (power of two)
  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 4;

  // Division by 4, 6 or 9 of a sum of at most nine channels
  localparam int SUM_WIDTH   = 12;
  localparam int RECIP_WIDTH = 14;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_WIDTH  = SUM_WIDTH + RECIP_WIDTH;
  localparam logic [RECIP_WIDTH-1:0] RECIP_6 = 14'd10923;  // ceil(2^16 / 6)
  localparam logic [RECIP_WIDTH-1:0] RECIP_9 = 14'd7282;   // ceil(2^16 / 9)

  typedef enum logic [1:0] {
    DIV_BY_4,
    DIV_BY_6,
    DIV_BY_9
  } div_e;

  typedef struct packed {
    logic [CHAN_WIDTH-1:0] red;
    logic [CHAN_WIDTH-1:0] green;
    logic [CHAN_WIDTH-1:0] blue;
  } rgb_t;

  // Classification of one item, made by the front end
  typedef struct packed {
    logic produce;    // item releases one output pixel
    logic top_cut;    // output pixel sits on the top row
    logic bot_cut;    // output pixel sits on the bottom row
    logic left_cut;   // output pixel sits on the left column
    logic right_cut;  // output pixel sits on the right column
    logic last;       // final output pixel of the frame
  } ctl_t;

  // One window column plus its classification
  typedef struct packed {
    rgb_t pix;
    rgb_t top;
    rgb_t mid;
    ctl_t ctl;
  } cmd_t;

  typedef struct packed {
    rgb_t mean;
    logic last;
  } out_t;

endpackage

/* rtl/core/box_blur_3x3_rgb_top.sv */
//----------------------------------------------------------------------------
// box_blur_3x3_rgb_top: 3x3 box filter on an RGB888 raster stream
// Each output pixel is the per-channel truncated mean of its in-image
// 3x3 neighbours (divided by 4 at corners, 6 on edges, 9 inside). Pixels
// enter in raster order with op = 0; output lags input by one row plus one
// pixel, so after the last pixel of a frame send frame_width + 1 flush
// beats (op = 1) to drain it, and out_last marks the frame's final pixel.
// Flush beats sent mid-frame are taken and dropped. Unless stalled, the
// block sustains one beat per clock on both sides, set by the two line
// stores, each doing one read and one write per cycle. A beat passes the
// line store read stage, command queue and averaging stages b1 and b2.
// Writing either geometry register restarts the frame; write only while
// the block is idle. There is no clearing pass after reset.
//----------------------------------------------------------------------------
module box_blur_3x3_rgb_top
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data_i,
  // input queue side
  input  logic                      push_i,
  output logic                      full_o,
  input  logic                      op_i,
  input  logic [CHAN_WIDTH-1:0]     in_red_i,
  input  logic [CHAN_WIDTH-1:0]     in_green_i,
  input  logic [CHAN_WIDTH-1:0]     in_blue_i,
  // result queue side
  input  logic                      pop_i,
  output logic                      empty_o,
  output logic [CHAN_WIDTH-1:0]     out_red_o,
  output logic [CHAN_WIDTH-1:0]     out_green_o,
  output logic [CHAN_WIDTH-1:0]     out_blue_o,
  output logic                      out_last_o
);

  localparam int CQ_CW = $clog2(CMDQ_DEPTH + 1);

  logic             cmd_valid, cmdq_full, cmdq_empty, cmd_pop;
  cmd_t             cmd_wr, cmd_rd;
  logic [CQ_CW-1:0] cmdq_count;
  logic [CQ_CW:0]   cmdq_level;
  out_t             res;

  assign cfg_ready_o = 1'b1;

  // Input stall: keep a slot for the beat in the line store read stage
  always_comb begin
    cmdq_level = (CQ_CW + 1)'(cmdq_count) + (CQ_CW + 1)'(cmd_valid);
    full_o     = (cmdq_level >= (CQ_CW + 1)'(CMDQ_DEPTH));
  end

  bb3_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push_i),
    .accept_ok_i(!full_o),
    .op_i       (op_i),
    .in_red_i   (in_red_i),
    .in_green_i (in_green_i),
    .in_blue_i  (in_blue_i),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd_wr)
  );

  // Queue between classification and averaging
  bb3_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMDQ_DEPTH)
  ) u_cmdq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_valid),
    .wdata_i(cmd_wr),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_rd),
    .empty_o(cmdq_empty),
    .full_o (cmdq_full),
    .count_o(cmdq_count)
  );

  bb3_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!cmdq_empty),
    .cmd_i      (cmd_rd),
    .cmd_pop_o  (cmd_pop),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_o      (res)
  );

  assign out_red_o   = res.mean.red;
  assign out_green_o = res.mean.green;
  assign out_blue_o  = res.mean.blue;
  assign out_last_o  = res.last;

  // Input stall reserves room for every beat leaving the front end
  a_cmdq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid |-> !cmdq_full)
    else $error("command queue overflow");

endmodule

/* rtl/core/bb3_ram.sv */
//----------------------------------------------------------------------------
// bb3_ram: simple dual-port RAM
// One write port, one read port, registered read returning old data.
//----------------------------------------------------------------------------
module bb3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/bb3_fifo.sv */
//----------------------------------------------------------------------------
// bb3_fifo: small register FIFO
// Fill count exposed so producers can reserve room for beats in flight.
//----------------------------------------------------------------------------
module bb3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q, count_d;

  // Fill count
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      count_q <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign count_o = count_q;

endmodule

/* rtl/core/bb3_front.sv */
//----------------------------------------------------------------------------
// bb3_front: input side of the box blur
// Holds geometry registers and raster counters, classifies each beat,
// and runs the two line stores that deliver a three-row window column.
//----------------------------------------------------------------------------
module bb3_front
  import bb3_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_valid_i,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data_i,
  // input beats
  input  logic                      push_i,
  input  logic                      accept_ok_i,
  input  logic                      op_i,
  input  logic [CHAN_WIDTH-1:0]     in_red_i,
  input  logic [CHAN_WIDTH-1:0]     in_green_i,
  input  logic [CHAN_WIDTH-1:0]     in_blue_i,
  // to the command queue
  output logic                      cmd_valid_o,
  output cmd_t                      cmd_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WEW = $clog2(MAX_WIDTH + 1);
  localparam int GW  = (WEW > FW_WIDTH) ? WEW : FW_WIDTH;

  logic [FW_WIDTH-1:0]  frame_width_q;
  logic [FH_WIDTH-1:0]  frame_height_q;
  logic [CW-1:0]        col_q, col_d;
  logic [ROW_WIDTH-1:0] row_q, row_d;

  logic [GW-1:0]        fw_ext, eff_w;
  logic [CW-1:0]        w_last;
  logic [FH_WIDTH-1:0]  h_last;
  logic [ROW_WIDTH-1:0] row_h, row_h1, h_last_ext;

  logic cfg_hit;
  logic take, act, in_image;
  logic col_zero, early;
  rgb_t pix;
  ctl_t ctl;

  logic          f1_valid_q;
  logic [CW-1:0] f1_col_q;
  rgb_t          f1_pix_q;
  ctl_t          f1_ctl_q;
  logic [23:0]   mid_rdata, top_rdata;

  // Effective geometry: width clamped to 3..MAX_WIDTH, height to at least 3
  always_comb begin
    fw_ext = GW'(frame_width_q);
    if (fw_ext < GW'(MIN_DIM)) begin
      eff_w = GW'(MIN_DIM);
    end else if (fw_ext > GW'(MAX_WIDTH)) begin
      eff_w = GW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    w_last = CW'(eff_w - GW'(1));
    if (frame_height_q < FH_WIDTH'(MIN_DIM)) begin
      h_last = FH_WIDTH'(MIN_DIM - 1);
    end else begin
      h_last = frame_height_q - FH_WIDTH'(1);
    end
    h_last_ext = ROW_WIDTH'(h_last);
    row_h      = h_last_ext + ROW_WIDTH'(1);
    row_h1     = h_last_ext + ROW_WIDTH'(2);
  end

  assign cfg_hit = cfg_valid_i &&
                   (cfg_index_i == REG_FRAME_WIDTH || cfg_index_i == REG_FRAME_HEIGHT);

  // Classify the beat
  always_comb begin
    take     = push_i && accept_ok_i;
    in_image = (row_q <= h_last_ext);
    // flush beats before the frame is complete are dropped
    act      = take && !(in_image && op_i == OP_FLUSH);
    col_zero = (col_q == '0);

    pix = '0;
    if (in_image) begin
      pix.red   = in_red_i;
      pix.green = in_green_i;
      pix.blue  = in_blue_i;
    end

    ctl.produce = (col_zero && row_q >= ROW_WIDTH'(2)) ||
                  (!col_zero && row_q != '0);
    // at column zero the right-border pixel of two rows up comes out
    early         = ctl.produce && col_zero;
    ctl.top_cut   = early ? (row_q == ROW_WIDTH'(2)) : (row_q == ROW_WIDTH'(1));
    ctl.bot_cut   = early ? (row_q == row_h1) : (row_q == row_h);
    ctl.left_cut  = !early && (col_q == CW'(1));
    ctl.right_cut = early;
    ctl.last      = early && (row_q == row_h1);
  end

  // Raster counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (act) begin
      if (row_q == row_h1) begin
        col_d = '0;
        row_d = '0;
      end else if (col_q == w_last) begin
        col_d = '0;
        row_d = row_q + ROW_WIDTH'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RESET;
      frame_height_q <= FRAME_HEIGHT_RESET;
      col_q          <= '0;
      row_q          <= '0;
      f1_valid_q     <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == REG_FRAME_WIDTH) begin
        frame_width_q <= cfg_data_i[FW_WIDTH-1:0];
      end
      if (cfg_valid_i && cfg_index_i == REG_FRAME_HEIGHT) begin
        frame_height_q <= cfg_data_i[FH_WIDTH-1:0];
      end
      col_q      <= col_d;
      row_q      <= row_d;
      f1_valid_q <= act && !cfg_hit;
    end
  end

  // Second stage waits for the line store read
  always_ff @(posedge clk_i) begin
    if (act) begin
      f1_col_q <= col_q;
      f1_pix_q <= pix;
      f1_ctl_q <= ctl;
    end
  end

  // Line store for the row above
  bb3_ram #(
    .WIDTH(24),
    .DEPTH(MAX_WIDTH)
  ) u_mid_ram (
    .clk_i  (clk_i),
    .we_i   (act),
    .waddr_i(col_q),
    .wdata_i(pix),
    .re_i   (act),
    .raddr_i(col_q),
    .rdata_o(mid_rdata)
  );

  // Line store for two rows above, fed from the row-above store
  bb3_ram #(
    .WIDTH(24),
    .DEPTH(MAX_WIDTH)
  ) u_top_ram (
    .clk_i  (clk_i),
    .we_i   (f1_valid_q),
    .waddr_i(f1_col_q),
    .wdata_i(mid_rdata),
    .re_i   (act),
    .raddr_i(col_q),
    .rdata_o(top_rdata)
  );

  assign cmd_valid_o = f1_valid_q;
  always_comb begin
    cmd_o     = '0;
    cmd_o.pix = f1_pix_q;
    cmd_o.top = top_rdata;
    cmd_o.mid = mid_rdata;
    cmd_o.ctl = f1_ctl_q;
  end

  // Counters stay inside the frame geometry
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= w_last)
    else $error("column counter beyond row width");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= row_h1)
    else $error("row counter beyond flush row");

endmodule

/* rtl/core/bb3_back.sv */
//----------------------------------------------------------------------------
// bb3_back: window and averaging side of the box blur
// Shifts window columns in, sums the in-image neighbours, divides by
// 4, 6 or 9 and queues the result.
//----------------------------------------------------------------------------
module bb3_back
  import bb3_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  // from the command queue
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  // result queue
  input  logic pop_i,
  output logic empty_o,
  output out_t out_o
);

  localparam int OQ_CW = $clog2(OUTQ_DEPTH + 1);

  rgb_t win_q [3][3];

  logic b1_valid_q;
  ctl_t b1_ctl_q;

  logic                 b2_valid_q;
  logic                 b2_last_q;
  div_e                 b2_div_q;
  logic [SUM_WIDTH-1:0] b2_sum_r_q, b2_sum_g_q, b2_sum_b_q;

  logic [SUM_WIDTH-1:0] sum_r, sum_g, sum_b;
  logic [2:0]           row_en, col_en;
  div_e                 div_sel;

  logic [RECIP_WIDTH-1:0] recip;
  logic [PROD_WIDTH-1:0]  prod_r, prod_g, prod_b;
  out_t                   res;

  logic [OQ_CW-1:0] oq_count;
  logic [OQ_CW:0]   oq_level;
  logic             oq_full, oq_pop;

  // Reserve result slots for beats still in the pipe
  always_comb begin
    oq_level  = (OQ_CW + 1)'(oq_count) + (OQ_CW + 1)'(b1_valid_q) +
                (OQ_CW + 1)'(b2_valid_q);
    cmd_pop_o = cmd_valid_i && (oq_level < (OQ_CW + 1)'(OUTQ_DEPTH));
  end

  // Window shift: new column enters on the right
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= cmd_i.top;
      win_q[1][2] <= cmd_i.mid;
      win_q[2][2] <= cmd_i.pix;
    end
  end

  // Masked neighbourhood sums
  always_comb begin
    row_en = {!b1_ctl_q.bot_cut, 1'b1, !b1_ctl_q.top_cut};
    col_en = {!b1_ctl_q.right_cut, 1'b1, !b1_ctl_q.left_cut};
    sum_r  = '0;
    sum_g  = '0;
    sum_b  = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (row_en[i] && col_en[j]) begin
          sum_r = sum_r + SUM_WIDTH'(win_q[i][j].red);
          sum_g = sum_g + SUM_WIDTH'(win_q[i][j].green);
          sum_b = sum_b + SUM_WIDTH'(win_q[i][j].blue);
        end
      end
    end
    if ((b1_ctl_q.top_cut || b1_ctl_q.bot_cut) &&
        (b1_ctl_q.left_cut || b1_ctl_q.right_cut)) begin
      div_sel = DIV_BY_4;
    end else if (b1_ctl_q.top_cut || b1_ctl_q.bot_cut ||
                 b1_ctl_q.left_cut || b1_ctl_q.right_cut) begin
      div_sel = DIV_BY_6;
    end else begin
      div_sel = DIV_BY_9;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
    end else begin
      b1_valid_q <= cmd_pop_o && cmd_i.ctl.produce;
      b2_valid_q <= b1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      b1_ctl_q <= cmd_i.ctl;
    end
    if (b1_valid_q) begin
      b2_sum_r_q <= sum_r;
      b2_sum_g_q <= sum_g;
      b2_sum_b_q <= sum_b;
      b2_div_q   <= div_sel;
      b2_last_q  <= b1_ctl_q.last;
    end
  end

  // Divide by reciprocal multiply; by four is a shift
  always_comb begin
    recip  = (b2_div_q == DIV_BY_6) ? RECIP_6 : RECIP_9;
    prod_r = PROD_WIDTH'(b2_sum_r_q) * PROD_WIDTH'(recip);
    prod_g = PROD_WIDTH'(b2_sum_g_q) * PROD_WIDTH'(recip);
    prod_b = PROD_WIDTH'(b2_sum_b_q) * PROD_WIDTH'(recip);
    res      = '0;
    res.last = b2_last_q;
    unique case (b2_div_q)
      DIV_BY_4: begin
        res.mean.red   = b2_sum_r_q[2 +: CHAN_WIDTH];
        res.mean.green = b2_sum_g_q[2 +: CHAN_WIDTH];
        res.mean.blue  = b2_sum_b_q[2 +: CHAN_WIDTH];
      end
      DIV_BY_6, DIV_BY_9: begin
        res.mean.red   = prod_r[RECIP_SHIFT +: CHAN_WIDTH];
        res.mean.green = prod_g[RECIP_SHIFT +: CHAN_WIDTH];
        res.mean.blue  = prod_b[RECIP_SHIFT +: CHAN_WIDTH];
      end
      default: begin
        res.mean = '0;
      end
    endcase
  end

  // Result queue
  assign oq_pop = pop_i && !empty_o;

  bb3_fifo #(
    .WIDTH($bits(out_t)),
    .DEPTH(OUTQ_DEPTH)
  ) u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (b2_valid_q),
    .wdata_i(res),
    .pop_i  (oq_pop),
    .rdata_o(out_o),
    .empty_o(empty_o),
    .full_o (oq_full),
    .count_o(oq_count)
  );

  // Credit scheme keeps the result queue from overflowing
  a_outq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b2_valid_q |-> !oq_full)
    else $error("result queue overflow");

  // The frame's final pixel is the bottom-right corner
  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b1_valid_q && b1_ctl_q.last) |-> (b1_ctl_q.bot_cut && b1_ctl_q.right_cut))
    else $error("last flag off the bottom-right corner");

endmodule
